// ===== design/rtcs_pkg.sv =====
// Shared constants, codes and request types of the rectangle table search unit.
`timescale 1ns / 1ps

package rtcs_pkg;

  localparam int MAX_RECTS_DEF  = 64;
  localparam int COORD_BITS_DEF = 10;

  localparam int FIELD_W = 10;   // coordinate field width on the channel
  localparam int IDX_W   = 6;    // match_index width
  localparam int CAP_W   = 7;    // capacity register width

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               operation;
    logic [FIELD_W-1:0] rect_top;
    logic [FIELD_W-1:0] rect_bottom;
    logic [FIELD_W-1:0] rect_left;
    logic [FIELD_W-1:0] rect_right;
  } in_req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic             stored;
  } out_req_t;

endpackage

// ===== design/rtcs_if.sv =====
// Valid/ready channel interfaces for the input and result requests.
`timescale 1ns / 1ps

interface rtcs_in_if;
  import rtcs_pkg::*;

  logic    valid;
  logic    ready;
  in_req_t req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface rtcs_out_if;
  import rtcs_pkg::*;

  logic     valid;
  logic     ready;
  out_req_t req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

// ===== design/rtcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rtcs_ram #(
  parameter int WIDTH  = 40,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rectangle_table_contain_search_unit.sv =====
// Top level of the rectangle table with first-match containment search.
`timescale 1ns / 1ps

// Usage
//   in_ch  : input requests (operation, rect_top/bottom/left/right), valid/ready.
//            operation add appends the rectangle while the table is below
//            min(capacity, MAX_RECTS); operation check scans the table.
//   out_ch : one result request per input request (found, match_index, stored).
//   cfg_we / cfg_wdata : writes the capacity register; write only while idle.
// Sequencing
//   add   : the input moves the sequencer to the finish state, which loads the
//           result into the output register once that register is free.
//   check : the scan reads stored entries in order and ends at the first match
//           or the last stored entry; then the finish state loads the result.
//           Empty table: no scan. The table RAM gives one entry per cycle.
//   in_ch.ready is high only while the sequencer is idle: one request at a time.
//   The next request can be taken in the cycle after a result is loaded.
// Reset: table empty, capacity 64, no result pending. RAM contents are not
//   cleared; entries are read only after they are written.
// Stall: a finished result sits in the output register until out_ch.ready;
//   the next input request is taken meanwhile, and its result waits in the
//   finish state until the output register frees up.
module rectangle_table_contain_search_unit #(
  parameter int MAX_RECTS  = rtcs_pkg::MAX_RECTS_DEF,
  parameter int COORD_BITS = rtcs_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  rtcs_in_if.sink                 in_ch,
  rtcs_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [rtcs_pkg::CAP_W-1:0] cfg_wdata
);
  import rtcs_pkg::*;

  // coordinate bits actually kept (field carries FIELD_W bits)
  localparam int W  = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CW = $clog2(MAX_RECTS + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;
  localparam int EW = 4 * W;

  state_t state, state_next;

  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]    count;     // stored entries
  logic [CW-1:0]    ptr;       // next entry to read
  logic             cmp_vld;   // RAM data is valid for cmp_idx
  logic [AW-1:0]    cmp_idx;

  // grown query
  logic [W-1:0]     q_gt, q_gl;
  logic [W:0]       q_gb, q_gr;

  // pending result
  logic             res_found;
  logic [AW-1:0]    res_idx;
  logic             res_stored;

  logic             out_valid;
  out_req_t         out_req;

  logic             accept;
  logic             is_add;
  logic             can_store;
  logic             rd_en;
  logic             hit;
  logic             last;
  logic             out_free;

  logic [W-1:0]     in_top, in_bottom, in_left, in_right;
  logic [EW-1:0]    wdata, rdata;
  logic [W-1:0]     e_top, e_bottom, e_left, e_right;

  assign in_top    = in_ch.req.rect_top[W-1:0];
  assign in_bottom = in_ch.req.rect_bottom[W-1:0];
  assign in_left   = in_ch.req.rect_left[W-1:0];
  assign in_right  = in_ch.req.rect_right[W-1:0];
  assign wdata     = {in_top, in_bottom, in_left, in_right};

  assign e_top    = rdata[4*W-1:3*W];
  assign e_bottom = rdata[3*W-1:2*W];
  assign e_left   = rdata[2*W-1:W];
  assign e_right  = rdata[W-1:0];

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_add      = (in_ch.req.operation == OP_ADD);
  assign can_store   = (MW'(count) < MW'(capacity)) && (count < CW'(MAX_RECTS));
  assign out_free    = !out_valid || out_ch.ready;

  // one entry read per cycle while scanning
  assign rd_en = (state == ST_SCAN) && (ptr < count);

  // the shared compare unit
  assign hit  = cmp_vld && (q_gt <= e_top) && (q_gb >= {1'b0, e_bottom}) &&
                (q_gl <= e_left) && (q_gr >= {1'b0, e_right});
  assign last = cmp_vld && ((CW'(cmp_idx) + CW'(1)) == count);

  rtcs_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_RECTS)
  ) u_table (
    .clk   (clk),
    .we    (accept && is_add && can_store),
    .waddr (count[AW-1:0]),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (ptr[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_add || (count == '0)) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit || last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      count     <= '0;
      ptr       <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept && is_add && can_store) begin
        count <= count + CW'(1);
      end
      if (accept) begin
        ptr <= '0;
      end else if (rd_en) begin
        ptr <= ptr + CW'(1);
      end
      cmp_vld <= rd_en;
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: query, scan index, result
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmp_idx <= ptr[AW-1:0];
    end
    if (accept) begin
      q_gt       <= (in_top == '0) ? '0 : in_top - W'(1);
      q_gl       <= (in_left == '0) ? '0 : in_left - W'(1);
      q_gb       <= {1'b0, in_bottom} + (W + 1)'(1);
      q_gr       <= {1'b0, in_right} + (W + 1)'(1);
      res_found  <= 1'b0;
      res_idx    <= '0;
      res_stored <= is_add && can_store;
    end else if ((state == ST_SCAN) && hit) begin
      res_found <= 1'b1;
      res_idx   <= cmp_idx;
    end
    if ((state == ST_FINISH) && out_free) begin
      out_req.found       <= res_found;
      out_req.match_index <= IDX_W'(res_idx);
      out_req.stored      <= res_stored;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.req   = out_req;

  // table never grows past its depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RECTS))
    else $error("entry count above table depth");

  // scan reads stay inside the written entries
  a_read_written: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (ptr < count))
    else $error("scan read of an unwritten entry");

  // an accepted add with room bumps the count by one
  a_add_count: assert property (@(posedge clk) disable iff (rst)
    (accept && is_add && can_store) |=> (count == $past(count) + CW'(1)))
    else $error("add did not advance entry count");

  // a result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> (out_valid && $stable(out_req)))
    else $error("pending result overwritten");

endmodule

// ===== verif/rectangle_table_contain_search_unit_test.sv =====
// Self-checking test of the rectangle table search unit: random traffic, capacity sweeps, scoreboard.
`timescale 1ns / 1ps

module rectangle_table_contain_search_unit_test;
  import rtcs_pkg::*;

  localparam int IDLE_PCT   = 18;         // chance in a hundred that a side idles
  localparam int CYCLE_CAP  = 1_000_000;  // run is killed past this many clocks
  localparam int SHOW_MAX   = 10;         // mismatches printed in full
  localparam int COORD_MAX  = (1 << FIELD_W) - 1;
  localparam int TAIL_WAIT  = 80;         // cycles after drain, covers a full scan

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  rtcs_in_if  in_ch ();
  rtcs_out_if out_ch ();

  rectangle_table_contain_search_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Requests waiting for the driver, and results owed by the block.
  in_req_t  pending_reqs[$];
  out_req_t owed_results[$];
  // Every add ever generated; checks are aimed at these.
  in_req_t  add_history[$];

  // Shadow of the block's table and capacity register.
  in_req_t  shadow_tbl[MAX_RECTS_DEF];
  int       shadow_count;
  int       shadow_cap;

  int  cycle_count;
  int  error_count;
  bit  in_taken;   // set at the edge a request is accepted, cleared by the driver
  bit  quiet;      // no idling on either side while set

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected result for one accepted request; updates the shadow table.
  function automatic out_req_t table_lookup(in_req_t r);
    out_req_t       res;
    logic [FIELD_W:0] g_top, g_bot, g_left, g_right;
    int             room;
    res = '0;
    if (r.operation == OP_ADD) begin
      room = (shadow_cap > MAX_RECTS_DEF) ? MAX_RECTS_DEF : shadow_cap;
      if (shadow_count < room) begin
        shadow_tbl[shadow_count] = r;
        shadow_count++;
        res.stored = 1'b1;
      end
    end else begin
      // grow the query by one; low edges stop at zero, high edges get a carry bit
      g_top   = (r.rect_top  == '0) ? '0 : {1'b0, r.rect_top}  - 1'b1;
      g_left  = (r.rect_left == '0) ? '0 : {1'b0, r.rect_left} - 1'b1;
      g_bot   = {1'b0, r.rect_bottom} + 1'b1;
      g_right = {1'b0, r.rect_right}  + 1'b1;
      for (int i = 0; i < shadow_count; i++) begin
        if (!res.found &&
            g_top   <= {1'b0, shadow_tbl[i].rect_top}    &&
            g_bot   >= {1'b0, shadow_tbl[i].rect_bottom} &&
            g_left  <= {1'b0, shadow_tbl[i].rect_left}   &&
            g_right >= {1'b0, shadow_tbl[i].rect_right}) begin
          res.found       = 1'b1;
          res.match_index = i[IDX_W-1:0];
        end
      end
    end
    return res;
  endfunction

  function automatic logic [FIELD_W-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_MAX[FIELD_W-1:0];
    return v[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] any_coord();
    return clip(int'($urandom_range(COORD_MAX)));
  endfunction

  // One random request. Adds are mostly small boxes so lookups hit varied
  // entries; checks are mostly aimed at earlier adds, edges jittered around
  // the grow-by-one boundary.
  function automatic in_req_t random_request(int add_pct);
    in_req_t r;
    in_req_t e;
    int      sel;
    r   = '0;
    sel = $urandom_range(99);
    if ($urandom_range(99) < add_pct) begin
      r.operation = OP_ADD;
      if (sel < 10) begin
        // arbitrary corners, often inverted
        r.rect_top    = any_coord();
        r.rect_bottom = any_coord();
        r.rect_left   = any_coord();
        r.rect_right  = any_coord();
      end else begin
        r.rect_top    = any_coord();
        r.rect_left   = any_coord();
        r.rect_bottom = clip(int'(r.rect_top)  + int'($urandom_range(15)));
        r.rect_right  = clip(int'(r.rect_left) + int'($urandom_range(15)));
      end
      add_history.push_back(r);
    end else begin
      r.operation = OP_CHECK;
      if (sel < 60 && add_history.size() > 0) begin
        e = add_history[$urandom_range(add_history.size() - 1)];
        r.rect_top    = clip(int'(e.rect_top)    - 1 + int'($urandom_range(3)));
        r.rect_left   = clip(int'(e.rect_left)   - 1 + int'($urandom_range(3)));
        r.rect_bottom = clip(int'(e.rect_bottom) + 1 - int'($urandom_range(3)));
        r.rect_right  = clip(int'(e.rect_right)  + 1 - int'($urandom_range(3)));
      end else if (sel < 80) begin
        r.rect_top    = any_coord();
        r.rect_bottom = any_coord();
        r.rect_left   = any_coord();
        r.rect_right  = any_coord();
      end else if (sel < 90) begin
        // near-full window
        r.rect_top    = clip(int'($urandom_range(3)));
        r.rect_left   = clip(int'($urandom_range(3)));
        r.rect_bottom = clip(COORD_MAX - int'($urandom_range(3)));
        r.rect_right  = clip(COORD_MAX - int'($urandom_range(3)));
      end else begin
        // corners of the coordinate range
        r.rect_top    = $urandom_range(1) ? COORD_MAX[FIELD_W-1:0] : '0;
        r.rect_bottom = $urandom_range(1) ? COORD_MAX[FIELD_W-1:0] : '0;
        r.rect_left   = $urandom_range(1) ? COORD_MAX[FIELD_W-1:0] : '0;
        r.rect_right  = $urandom_range(1) ? COORD_MAX[FIELD_W-1:0] : '0;
      end
    end
    return r;
  endfunction

  function automatic void push_req(logic op, int t, int b, int l, int rr);
    in_req_t r;
    r.operation   = op;
    r.rect_top    = clip(t);
    r.rect_bottom = clip(b);
    r.rect_left   = clip(l);
    r.rect_right  = clip(rr);
    if (op == OP_ADD) add_history.push_back(r);
    pending_reqs.push_back(r);
  endfunction

  task automatic queue_random(int n, int add_pct);
    repeat (n) pending_reqs.push_back(random_request(add_pct));
  endtask

  // Sender holds off until every owed result is back and the block is idle.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || owed_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(int v);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[CAP_W-1:0];
    @(posedge clk);
    shadow_cap = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Request driver: one update per falling edge, holds the request until taken.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (!in_ch.valid || in_taken) begin
        if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.req   <= pending_reqs.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      in_taken = 1'b0;
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: check results first, then predict for a request taken at this edge.
  always @(posedge clk) begin
    out_req_t want;
    out_req_t got;
    cycle_count++;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.req;
        if (owed_results.size() == 0) begin
          error_count++;
          if (error_count <= SHOW_MAX)
            $display("[%0t] unexpected result found=%0d idx=%0d stored=%0d",
                     $realtime, got.found, got.match_index, got.stored);
        end else begin
          want = owed_results.pop_front();
          if (got.found !== want.found || got.match_index !== want.match_index ||
              got.stored !== want.stored) begin
            error_count++;
            if (error_count <= SHOW_MAX)
              $display("[%0t] mismatch exp found=%0d idx=%0d stored=%0d, got found=%0d idx=%0d stored=%0d",
                       $realtime, want.found, want.match_index, want.stored,
                       got.found, got.match_index, got.stored);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        owed_results.push_back(table_lookup(in_ch.req));
        in_taken = 1'b1;
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_CAP);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.req    = '0;
    out_ch.ready = 1'b0;
    in_taken     = 1'b0;
    quiet        = 1'b0;
    cycle_count  = 0;
    error_count  = 0;
    shadow_count = 0;
    shadow_cap   = int'(CAP_RESET);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, coordinate extremes, low-edge saturation,
    // carry on the high edges, inverted boxes, first-match ordering.
    push_req(OP_CHECK, 0, 0, 0, 0);
    push_req(OP_CHECK, 0, COORD_MAX, 0, COORD_MAX);
    push_req(OP_ADD, 0, 0, 0, 0);
    push_req(OP_ADD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    push_req(OP_ADD, 0, COORD_MAX, 0, COORD_MAX);
    push_req(OP_ADD, 512, 600, 100, 200);
    push_req(OP_ADD, 700, 650, 900, 800);
    push_req(OP_CHECK, 1, 0, 1, 0);
    push_req(OP_CHECK, 0, 0, 0, 0);
    push_req(OP_CHECK, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    push_req(OP_CHECK, 513, 599, 101, 199);
    push_req(OP_CHECK, 514, 599, 101, 199);
    push_req(OP_CHECK, 701, 649, 901, 799);
    push_req(OP_CHECK, 600, 400, 500, 300);
    push_req(OP_CHECK, 0, COORD_MAX, 0, COORD_MAX);

    // capacity below the fill level: adds dropped, scans still cover all entries
    write_capacity(0);
    queue_random(40, 30);
    write_capacity(8);
    queue_random(60, 30);
    write_capacity(20);
    queue_random(150, 15);
    write_capacity(12);
    queue_random(60, 30);

    // stretch with no idling on either side
    write_capacity(40);
    quiet = 1'b1;
    queue_random(150, 15);
    wait_drained();
    quiet = 1'b0;

    // above the table size: clamps, table fills and further adds drop
    write_capacity(127);
    queue_random(300, 10);
    write_capacity(MAX_RECTS_DEF);
    queue_random(200, 10);
    write_capacity(100);
    queue_random(140, 10);

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
